/* hdl/priority_job_scheduler_assert.svh */
// Assertion macros used by the scheduler top level.
`ifndef PRIORITY_JOB_SCHEDULER_ASSERT_SVH
`define PRIORITY_JOB_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define PJS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define PJS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pjs_pkg.sv */
package pjs_pkg;

  localparam int ARR_W      = 16;
  localparam int BURST_W    = 16;
  localparam int PRI_W      = 8;
  localparam int TICK_W     = 23;
  localparam int IDX_OUT_W  = 6;
  localparam int JOB_W      = ARR_W + BURST_W + PRI_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  // arrival in the lowest bits, as on the input bus
  typedef struct packed {
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arr;
  } pjs_job_t;

  // best candidate held during a scan
  typedef struct packed {
    logic               found;
    logic [PRI_W-1:0]   pri;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
  } pjs_best_t;

  typedef struct packed {
    logic take_pri;
    logic take_early;
  } pjs_take_t;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_RUN   = 6'b000100,
    S_RREQ  = 6'b001000,
    S_RDATA = 6'b010000,
    S_ROUT  = 6'b100000
  } pjs_state_t;

endpackage

/* hdl/pjs_ram.sv */
module pjs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pjs_select.sv */
module pjs_select (
  input  pjs_pkg::pjs_job_t               cand,
  input  logic                            cand_marked,
  input  logic                            cand_is_first,
  input  logic                            first_pass,
  input  logic [pjs_pkg::TICK_W-1:0]      tick,
  input  pjs_pkg::pjs_best_t              pbest,
  input  pjs_pkg::pjs_best_t              ebest,
  output pjs_pkg::pjs_take_t              take
);
  import pjs_pkg::*;

  logic arrived;
  logic elig;

  // first pass of a batch: only load position zero may run
  assign arrived = first_pass ? cand_is_first
                              : ({{(TICK_W-ARR_W){1'b0}}, cand.arr} <= tick);
  assign elig    = !cand_marked && arrived;

  // strict compares keep ties on the lower load position
  assign take.take_pri   = elig && (!pbest.found || (cand.pri < pbest.pri));
  assign take.take_early = !cand_marked && (!ebest.found || (cand.arr < ebest.arr));

endmodule

/* hdl/priority_job_scheduler.sv */
// Non-preemptive priority scheduler for a batch of up to MAX_JOBS jobs. Each accepted input
// request loads one job; the request flagged with in_tlast closes the batch and the block
// stops taking input. Job 0 runs first; every slot, the first one included, is chosen by a
// full scan of the job table through its single read port, followed by the run state that
// starts the pick. One report per job, in load order, then follows through the read request,
// read data and output states, held while the sink holds out_tready low; after the last
// report is taken the block is ready for the next batch. Jobs beyond MAX_JOBS are dropped,
// but a dropped job carrying in_tlast still starts scheduling.
`include "priority_job_scheduler_assert.svh"

module priority_job_scheduler #(
  parameter int MAX_JOBS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] arrival_time, [31:16] burst_time, [39:32] job_priority
  input  logic [pjs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,   // last_job
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [5:0] job_index, [28:6] completion_time, [51:29] turnaround_time,
  // [74:52] waiting_time, [79:75] zero
  output logic [pjs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast   // last_report
);
  import pjs_pkg::*;

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_JOBS);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  pjs_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              dv_r, dv_nxt;
  logic [IDX_W-1:0]  di_r, di_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              first_r, first_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  pjs_best_t         pbest_r, pbest_nxt;
  pjs_best_t         ebest_r, ebest_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [IDX_W-1:0]  eidx_r, eidx_nxt;
  logic [MAX_JOBS-1:0] marks_r, marks_nxt;
  logic [IDX_W-1:0]  rep_r, rep_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_acc;
  logic              job_we;
  pjs_job_t          job_wdata;
  pjs_job_t          job_rd;
  logic [IDX_W-1:0]  raddr;
  logic              fin_we;
  logic [IDX_W-1:0]  fin_waddr;
  logic [TICK_W-1:0] fin_rd;
  pjs_take_t         take;
  pjs_best_t         run_job;
  logic [IDX_W-1:0]  run_idx;
  logic [TICK_W-1:0] arr_ext;
  logic [TICK_W-1:0] start;
  logic [TICK_W-1:0] sum;
  logic [TICK_W-1:0] turn;
  logic [TICK_W-1:0] wait_t;
  logic              rep_last;

  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_ROUT);
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign job_we    = in_acc && (count_r < FULL_CNT);
  assign job_wdata = pjs_job_t'(in_tdata[JOB_W-1:0]);
  assign raddr     = (state_r == S_SCAN) ? addr_r[IDX_W-1:0] : rep_r;

  pjs_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (job_wdata),
    .raddr (raddr),
    .rdata (job_rd)
  );

  pjs_ram #(.WIDTH(TICK_W), .DEPTH(MAX_JOBS)) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (fin_waddr),
    .wdata (tick_nxt),
    .raddr (raddr),
    .rdata (fin_rd)
  );

  pjs_select u_select (
    .cand          (job_rd),
    .cand_marked   (marks_r[di_r]),
    .cand_is_first (di_r == '0),
    .first_pass    (first_r),
    .tick          (tick_r),
    .pbest         (pbest_r),
    .ebest         (ebest_r),
    .take          (take)
  );

  // falls back to the earliest arrival when nothing has arrived yet
  assign run_job = pbest_r.found ? pbest_r : ebest_r;
  assign run_idx = pbest_r.found ? pidx_r : eidx_r;
  assign arr_ext = {{(TICK_W-ARR_W){1'b0}}, run_job.arr};
  assign start   = (tick_r >= arr_ext) ? tick_r : arr_ext;
  assign sum     = start + {{(TICK_W-BURST_W){1'b0}}, run_job.burst};

  assign turn     = fin_rd - {{(TICK_W-ARR_W){1'b0}}, job_rd.arr};
  assign wait_t   = turn - {{(TICK_W-BURST_W){1'b0}}, job_rd.burst};
  assign rep_last = (CNT_W'(rep_r) == (count_r - ONE_CNT));

  assign fin_we    = (state_r == S_RUN);
  assign fin_waddr = run_idx;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    dv_nxt       = dv_r;
    di_nxt       = di_r;
    k_nxt        = k_r;
    first_nxt    = first_r;
    tick_nxt     = tick_r;
    pbest_nxt    = pbest_r;
    ebest_nxt    = ebest_r;
    pidx_nxt     = pidx_r;
    eidx_nxt     = eidx_r;
    marks_nxt    = marks_r;
    rep_nxt      = rep_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (job_we) begin
            count_nxt = count_r + ONE_CNT;
          end
          if (in_tlast) begin
            state_nxt       = S_SCAN;
            first_nxt       = 1'b1;
            k_nxt           = '0;
            tick_nxt        = '0;
            addr_nxt        = '0;
            dv_nxt          = 1'b0;
            pbest_nxt.found = 1'b0;
            ebest_nxt.found = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (addr_r < count_r) begin
          addr_nxt = addr_r + ONE_CNT;
          dv_nxt   = 1'b1;
          di_nxt   = addr_r[IDX_W-1:0];
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r) begin
          if (take.take_pri) begin
            pbest_nxt = '{found: 1'b1, pri: job_rd.pri, arr: job_rd.arr,
                          burst: job_rd.burst};
            pidx_nxt  = di_r;
          end
          if (take.take_early) begin
            ebest_nxt = '{found: 1'b1, pri: job_rd.pri, arr: job_rd.arr,
                          burst: job_rd.burst};
            eidx_nxt  = di_r;
          end
        end else if (addr_r == count_r) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        tick_nxt           = sum;
        marks_nxt[run_idx] = 1'b1;
        first_nxt          = 1'b0;
        k_nxt              = k_r + ONE_CNT;
        if ((k_r + ONE_CNT) == count_r) begin
          state_nxt = S_RREQ;
          rep_nxt   = '0;
        end else begin
          state_nxt       = S_SCAN;
          addr_nxt        = '0;
          dv_nxt          = 1'b0;
          pbest_nxt.found = 1'b0;
          ebest_nxt.found = 1'b0;
        end
      end
      S_RREQ: begin
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        out_data_nxt = {{(OUT_DATA_W-IDX_OUT_W-3*TICK_W){1'b0}},
                        wait_t, turn, fin_rd, IDX_OUT_W'(rep_r)};
        out_last_nxt = rep_last;
        state_nxt    = S_ROUT;
      end
      S_ROUT: begin
        if (out_tready) begin
          if (rep_last) begin
            marks_nxt = '0;
            count_nxt = '0;
            tick_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            rep_nxt   = rep_r + 1'b1;
            state_nxt = S_RREQ;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      addr_r  <= '0;
      dv_r    <= 1'b0;
      k_r     <= '0;
      first_r <= 1'b0;
      tick_r  <= '0;
      marks_r <= '0;
      rep_r   <= '0;
      pbest_r <= '0;
      ebest_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      dv_r    <= dv_nxt;
      k_r     <= k_nxt;
      first_r <= first_nxt;
      tick_r  <= tick_nxt;
      marks_r <= marks_nxt;
      rep_r   <= rep_nxt;
      pbest_r <= pbest_nxt;
      ebest_r <= ebest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    di_r          <= di_nxt;
    pidx_r        <= pidx_nxt;
    eidx_r        <= eidx_nxt;
    out_data_r    <= out_data_nxt;
    out_last_r    <= out_last_nxt;
  end

  // a run slot always has a pick: either an arrived job or the earliest left
  `PJS_ASSERT_NOW(a_run_has_pick, state_r == S_RUN, pbest_r.found || ebest_r.found,
                  "run slot without a picked job")
  // never scan once every loaded job has been scheduled
  `PJS_ASSERT_NOW(a_scan_bound, state_r == S_SCAN, k_r < count_r,
                  "scan started with no job left")
  // the picked job must still be unscheduled
  `PJS_ASSERT_NOW(a_pick_unmarked, state_r == S_RUN, !marks_r[run_idx],
                  "picked job already scheduled")
  // final report taken returns the block to loading with an empty table
  `PJS_ASSERT_NEXT(a_batch_done, out_tvalid && out_tready && out_tlast,
                   in_tready && (count_r == '0) && (marks_r == '0),
                   "batch not cleared after final report")

endmodule

/* tb/priority_job_scheduler_checker.sv */
module priority_job_scheduler_checker #(
  parameter int MAX_JOBS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [pjs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                         in_tlast,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [pjs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                         out_tlast,
  output int                           mismatches,
  output int                           pending,
  output int                           reports_checked
);
  import pjs_pkg::*;

  localparam int PAD_W = OUT_DATA_W - 3 * TICK_W - IDX_OUT_W;

  // job_index lowest, padding on top, as on out_tdata
  typedef struct packed {
    logic [PAD_W-1:0]     pad;
    logic [TICK_W-1:0]    waited;
    logic [TICK_W-1:0]    turnaround;
    logic [TICK_W-1:0]    completion;
    logic [IDX_OUT_W-1:0] idx;
  } job_report_t;

  typedef struct {
    job_report_t data;
    logic        is_last;
  } report_item_t;

  pjs_job_t     batch_q[$];
  report_item_t report_q[$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    reports_checked = 0;
  end

  // Non-preemptive priority schedule of the loaded batch; queues one report per job.
  function automatic void schedule_batch();
    int                n;
    int                i;
    int                k;
    int                pick;
    bit                found;
    logic [TICK_W-1:0] now_tick;
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] fin [MAX_JOBS];
    bit                done [MAX_JOBS];
    report_item_t      r;
    n = batch_q.size();
    now_tick = '0;
    for (i = 0; i < MAX_JOBS; i++) begin
      done[i] = 1'b0;
      fin[i]  = '0;
    end
    for (k = 0; k < n; k++) begin
      pick  = 0;
      found = (k == 0);
      // best priority among jobs already arrived
      for (i = 0; i < n && k > 0; i++) begin
        if (!done[i] && TICK_W'(batch_q[i].arr) <= now_tick) begin
          if (!found || batch_q[i].pri < batch_q[pick].pri) begin
            pick  = i;
            found = 1'b1;
          end
        end
      end
      // nothing waiting: earliest arrival, processor idles until then
      for (i = 0; i < n && !found; i++) begin
        if (!done[i]) begin
          pick  = i;
          found = 1'b1;
        end
      end
      for (i = pick + 1; i < n && k > 0 && TICK_W'(batch_q[pick].arr) > now_tick; i++) begin
        if (!done[i] && batch_q[i].arr < batch_q[pick].arr)
          pick = i;
      end
      start = (TICK_W'(batch_q[pick].arr) > now_tick) ? TICK_W'(batch_q[pick].arr) : now_tick;
      now_tick   = start + TICK_W'(batch_q[pick].burst);
      fin[pick]  = now_tick;
      done[pick] = 1'b1;
    end
    for (i = 0; i < n; i++) begin
      r.data.pad        = '0;
      r.data.idx        = IDX_OUT_W'(i);
      r.data.completion = fin[i];
      r.data.turnaround = fin[i] - TICK_W'(batch_q[i].arr);
      r.data.waited     = r.data.turnaround - TICK_W'(batch_q[i].burst);
      r.is_last         = (i == n - 1);
      report_q.push_back(r);
    end
    batch_q.delete();
  endfunction

  task automatic compare_field(input string name, input int job, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: job %0d %s expected %0d, got %0d", $time, job, name, want, got);
    end
  endtask

  task automatic check_report(input job_report_t got, input logic got_last);
    report_item_t want;
    if (report_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected report, expected none, got %h last %b", $time, got, got_last);
    end else begin
      want = report_q.pop_front();
      compare_field("job_index", want.data.idx, want.data.idx, got.idx);
      compare_field("completion_time", want.data.idx, want.data.completion, got.completion);
      compare_field("turnaround_time", want.data.idx, want.data.turnaround, got.turnaround);
      compare_field("waiting_time", want.data.idx, want.data.waited, got.waited);
      compare_field("padding", want.data.idx, want.data.pad, got.pad);
      compare_field("last_report", want.data.idx, want.is_last, got_last);
      reports_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        // requests past a full table are dropped, but tlast still closes the batch
        if (batch_q.size() < MAX_JOBS)
          batch_q.push_back(pjs_job_t'(in_tdata));
        if (in_tlast)
          schedule_batch();
      end
      if (out_tvalid && out_tready)
        check_report(job_report_t'(out_tdata), out_tlast);
    end
    pending <= report_q.size();
  end

endmodule

/* tb/priority_job_scheduler_tb.sv */
module priority_job_scheduler_tb;
  import pjs_pkg::*;

  localparam int MAX_JOBS    = 64;
  localparam int QUIET_LIMIT = 40000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int jobs_sent     = 0;
  int batches_sent  = 0;
  int quiet_cycles  = 0;
  int mismatches;
  int pending;
  int reports_checked;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  priority_job_scheduler #(
    .MAX_JOBS(MAX_JOBS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  priority_job_scheduler_checker #(
    .MAX_JOBS(MAX_JOBS)
  ) sched_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .pending        (pending),
    .reports_checked(reports_checked)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // scheduling 64 jobs is the longest quiet stretch
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request or report accepted for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                          input logic [PRI_W-1:0] pri, input bit is_last);
    pjs_job_t job;
    job.arr   = arr;
    job.burst = burst;
    job.pri   = pri;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= job;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    jobs_sent++;
    if (is_last)
      batches_sent++;
  endtask

  task automatic drain_reports();
    in_tvalid <= 1'b0;
    do
      @(posedge clk);
    while (pending != 0);
  endtask

  // Mostly ordered arrivals; spread picks between heavy contention and idle gaps.
  task automatic random_batch(input int size);
    int a;
    int spread;
    int burst_span;
    int pri_span;
    int j;
    logic [BURST_W-1:0] burst;
    case ($urandom_range(3))
      0:       spread = 0;
      1:       spread = 4;
      2:       spread = 60;
      default: spread = 3000;
    endcase
    case ($urandom_range(2))
      0:       burst_span = 8;
      1:       burst_span = 400;
      default: burst_span = 65535;
    endcase
    pri_span = $urandom_range(1) ? 3 : 255;
    a = $urandom_range(1) ? 0 : $urandom_range(0, 2000);
    for (j = 0; j < size; j++) begin
      if ($urandom_range(9) == 0)
        a = $urandom_range(0, 65535);   // out-of-order or wide arrival
      else
        a = a + $urandom_range(0, spread);
      if (a > 65535)
        a = 65535;
      burst = ($urandom_range(29) == 0) ? '0 : BURST_W'($urandom_range(1, burst_span));
      send_job(ARR_W'(a), burst, PRI_W'($urandom_range(0, pri_span)), j == size - 1);
    end
  endtask

  initial begin
    int phase;
    int phase_start;
    int size;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, zero burst and an arrival earlier than its predecessor
    send_job(16'h0000, 16'hFFFF, 8'hFF, 1'b0);
    send_job(16'h0000, 16'h0001, 8'h00, 1'b0);
    send_job(16'hFFFF, 16'h0000, 8'h80, 1'b0);
    send_job(16'h0005, 16'h0003, 8'h00, 1'b1);
    // lone job
    send_job(16'h1234, 16'h00FF, 8'h7F, 1'b1);
    // processor idles between arrivals, then a three-way arrival tie
    send_job(16'd10, 16'd5, 8'd9, 1'b0);
    send_job(16'd100, 16'd7, 8'd3, 1'b0);
    send_job(16'd200, 16'd4, 8'd1, 1'b0);
    send_job(16'd200, 16'd6, 8'd1, 1'b0);
    send_job(16'd200, 16'd2, 8'd0, 1'b1);
    // everyone waiting at once: priority order, ties to load order
    send_job(16'd0, 16'd3, 8'd3, 1'b0);
    send_job(16'd0, 16'd1, 8'd2, 1'b0);
    send_job(16'd0, 16'd4, 8'd2, 1'b0);
    send_job(16'd0, 16'd1, 8'd0, 1'b0);
    send_job(16'd0, 16'd5, 8'd1, 1'b0);
    send_job(16'd0, 16'd9, 8'd0, 1'b1);
    drain_reports();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 86;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct     = 28;
        end
      endcase
      phase_start = jobs_sent;
      // full table, then one and two requests beyond it
      if (phase < 3)
        random_batch(MAX_JOBS + phase);
      while (jobs_sent - phase_start < 120) begin
        size = $urandom_range(1, 12);
        random_batch(size);
      end
      drain_reports();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d jobs in %0d batches: full-table overflow, idle gaps, priority ties,",
             jobs_sent, batches_sent);
    $display("zero bursts, out-of-order arrivals under four flow-control mixes; %0d reports",
             reports_checked);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/pjs_pkg.sv
hdl/pjs_ram.sv
hdl/pjs_select.sv
hdl/priority_job_scheduler.sv
tb/priority_job_scheduler_checker.sv
tb/priority_job_scheduler_tb.sv
